// ===== src/bhlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded history list package
// Action, status and scan mode codes, field widths, configuration indexes,
// default sizes and the result record for the history list modules.
// ----------------------------------------------------------------------------
package bhlc_pkg;

    // Default sizes
    localparam int DEPTH_DEF     = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int ACT_W     = 3;
    localparam int IN_KEY_W  = 32;
    localparam int OFFSET_W  = 8;
    localparam int LIMIT_W   = 7;
    localparam int STATUS_W  = 2;
    localparam int OUT_KEY_W = 32;
    localparam int POS_W     = 6;
    localparam int CAP_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    // Actions
    localparam logic [ACT_W-1:0] ACT_ADD       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GOTO      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ_REL  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ_BACK = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ_FWD  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Scan modes
    localparam logic [1:0] MODE_GOTO = 2'd0;
    localparam logic [1:0] MODE_REL  = 2'd1;
    localparam logic [1:0] MODE_LIST = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_KEY_W-1:0] key;
        logic [POS_W-1:0]     position;
        logic [POS_W-1:0]     back;
        logic [POS_W-1:0]     fwd;
        logic                 present;
        logic                 evicted;
        logic                 changed;
        logic                 last;
    } result_t;

endpackage

// ===== src/bounded_history_list_cursor.sv =====
// ----------------------------------------------------------------------------
// Bounded history list with cursor
// Keeps up to DEPTH keys in a ring of cells with a cursor; supports add,
// go-to, relative read and back/forward list reads.
// ----------------------------------------------------------------------------
// Add and any ignored request: one result on the cycle after acceptance,
//   and the next request may start in that same cycle.
// Go-to, relative read and list reads: busy while the cell ring rotates
//   once; results come out as the entries pass cell zero.
// List reads emit one result per cycle, up to limit results.
// Reset: empty list, no cursor, capacity 64, adding enabled.
module bounded_history_list_cursor #(
    parameter int DEPTH     = bhlc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = bhlc_pkg::KEY_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bhlc_pkg::ACT_W-1:0]        action,
    input  logic [bhlc_pkg::IN_KEY_W-1:0]     item_key,
    input  logic signed [bhlc_pkg::OFFSET_W-1:0] offset,
    input  logic [bhlc_pkg::LIMIT_W-1:0]      limit,
    output logic                              result_valid,
    output logic [bhlc_pkg::STATUS_W-1:0]     status,
    output logic [bhlc_pkg::OUT_KEY_W-1:0]    result_key,
    output logic [bhlc_pkg::POS_W-1:0]        result_position,
    output logic [bhlc_pkg::POS_W-1:0]        back_count,
    output logic [bhlc_pkg::POS_W-1:0]        forward_count,
    output logic                              current_present,
    output logic                              evicted,
    output logic                              changed,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bhlc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bhlc_pkg::CFG_DAT_W-1:0]    cfg_data
);

    import bhlc_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = IW + 9;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Control state
    logic             state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [IW-1:0]    cur_reg, cur_next;
    logic [IW-1:0]    step_reg, step_next;
    logic [1:0]       mode_reg, mode_next;
    logic             found_reg, found_next;
    logic             res_v_reg, res_v_next;
    logic [CAP_W-1:0] cap_reg;
    logic             en_reg;

    // Payload
    logic [KEY_WIDTH-1:0] seek_reg, seek_next;
    logic [IW-1:0]        tgt_reg, tgt_next;
    logic [IW-1:0]        lastp_reg, lastp_next;
    result_t              res_reg, res_next;

    // Cell ring
    logic [KEY_WIDTH-1:0] cell_key [DEPTH];
    logic                 shift;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    logic [KEY_WIDTH-1:0] in_key;

    // Derived values
    logic                 have;
    logic [CW-1:0]        cap_eff;
    logic [CW-1:0]        back_now;
    logic [CW-1:0]        fwd_now;
    logic [CW-1:0]        base;
    logic                 evict;
    logic [CW-1:0]        n1;
    logic signed [PW-1:0] rel_pos;
    logic                 rel_ok;
    logic [CW-1:0]        side_cnt;
    logic [CW-1:0]        size;
    logic [CW-1:0]        lo;
    logic                 scan_end;
    result_t              ign_res;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            bhlc_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .IW        (IW),
                .INDEX     (g)
            ) u_cell (
                .clk      (clk),
                .shift    (shift),
                .next_key (cell_key[(g + 1) % DEPTH]),
                .wr_en    (wr_en),
                .wr_idx   (wr_idx),
                .wr_key   (in_key),
                .key      (cell_key[g])
            );
        end
    endgenerate

    assign in_key   = KEY_WIDTH'(item_key);
    assign have     = (cnt_reg != '0);
    assign cap_eff  = (cap_reg > CAP_W'(DEPTH)) ? CW'(DEPTH) : CW'(cap_reg);
    assign back_now = have ? CW'(cur_reg) : '0;
    assign fwd_now  = have ? (cnt_reg - CW'(cur_reg) - CW'(1)) : '0;

    // Add: truncate after the cursor, then drop the oldest when full
    assign base  = have ? (CW'(cur_reg) + CW'(1)) : '0;
    assign evict = (base != '0) && (base >= cap_eff)
                   && ((cur_reg != '0) || (cap_eff == CW'(1)));

    always_comb
    begin
        n1 = base - CW'(evict);
        if (n1 >= CW'(DEPTH))
        begin
            n1 = CW'(DEPTH - 1);
        end
    end

    assign rel_pos = $signed({{(PW - IW){1'b0}}, cur_reg}) + PW'(offset);
    assign rel_ok  = !rel_pos[PW-1]
                     && (rel_pos < $signed({{(PW - CW){1'b0}}, cnt_reg}));

    assign side_cnt = (action == ACT_READ_BACK) ? back_now : fwd_now;
    assign size     = (8'(side_cnt) > 8'(limit)) ? CW'(limit) : side_cnt;
    assign lo       = (action == ACT_READ_BACK) ? (back_now - size)
                                                : (CW'(cur_reg) + CW'(1));

    assign scan_end = (step_reg == IW'(DEPTH - 1));

    always_comb
    begin
        ign_res          = '0;
        ign_res.status   = STAT_IGNORED;
        ign_res.position = POS_W'(have ? cur_reg : '0);
        ign_res.back     = POS_W'(back_now);
        ign_res.fwd      = POS_W'(fwd_now);
        ign_res.present  = have;
        ign_res.last     = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        step_next  = step_reg;
        mode_next  = mode_reg;
        found_next = found_reg;
        seek_next  = seek_reg;
        tgt_next   = tgt_reg;
        lastp_next = lastp_reg;
        res_next   = res_reg;
        res_v_next = 1'b0;
        shift      = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = n1[IW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_ADD:
                        begin
                            res_v_next = 1'b1;
                            if ((cap_eff == '0) || !en_reg)
                            begin
                                res_next = ign_res;
                            end
                            else
                            begin
                                wr_en             = 1'b1;
                                shift             = evict;
                                cur_next          = n1[IW-1:0];
                                cnt_next          = n1 + CW'(1);
                                res_next          = '0;
                                res_next.status   = STAT_DONE;
                                res_next.key      = OUT_KEY_W'(in_key);
                                res_next.position = POS_W'(n1);
                                res_next.back     = POS_W'(n1);
                                res_next.present  = 1'b1;
                                res_next.evicted  = evict;
                                res_next.changed  = 1'b1;
                                res_next.last     = 1'b1;
                            end
                        end
                        ACT_GOTO:
                        begin
                            if (!have || (in_key == '0))
                            begin
                                res_v_next = 1'b1;
                                res_next   = ign_res;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                mode_next  = MODE_GOTO;
                                found_next = 1'b0;
                                seek_next  = in_key;
                                step_next  = '0;
                            end
                        end
                        ACT_READ_REL:
                        begin
                            if (!have)
                            begin
                                res_v_next = 1'b1;
                                res_next   = ign_res;
                            end
                            else if (!rel_ok)
                            begin
                                res_v_next      = 1'b1;
                                res_next        = ign_res;
                                res_next.status = STAT_MISS;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                mode_next  = MODE_REL;
                                tgt_next   = rel_pos[IW-1:0];
                                step_next  = '0;
                            end
                        end
                        ACT_READ_BACK, ACT_READ_FWD:
                        begin
                            // nothing to emit: stay idle, no result
                            if (size != '0)
                            begin
                                state_next = ST_SCAN;
                                mode_next  = MODE_LIST;
                                tgt_next   = lo[IW-1:0];
                                lastp_next = IW'(lo + size - CW'(1));
                                step_next  = '0;
                            end
                        end
                        default:
                        begin
                            res_v_next = 1'b1;
                            res_next   = ign_res;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // rotate the ring; cell zero holds entry step_reg
                shift     = 1'b1;
                step_next = scan_end ? '0 : (step_reg + IW'(1));
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end

                unique case (mode_reg)
                    MODE_GOTO:
                    begin
                        if (!found_reg && (CW'(step_reg) < cnt_reg)
                            && (cell_key[0] == seek_reg))
                        begin
                            found_next        = 1'b1;
                            cur_next          = step_reg;
                            res_v_next        = 1'b1;
                            res_next          = '0;
                            res_next.status   = STAT_DONE;
                            res_next.key      = OUT_KEY_W'(cell_key[0]);
                            res_next.position = POS_W'(step_reg);
                            res_next.back     = POS_W'(step_reg);
                            res_next.fwd      = POS_W'(cnt_reg - CW'(step_reg) - CW'(1));
                            res_next.present  = 1'b1;
                            res_next.changed  = 1'b1;
                            res_next.last     = 1'b1;
                        end
                        else if (scan_end && !found_reg)
                        begin
                            res_v_next      = 1'b1;
                            res_next        = ign_res;
                            res_next.status = STAT_MISS;
                        end
                    end
                    MODE_REL:
                    begin
                        if (step_reg == tgt_reg)
                        begin
                            res_v_next        = 1'b1;
                            res_next          = ign_res;
                            res_next.status   = STAT_DONE;
                            res_next.key      = OUT_KEY_W'(cell_key[0]);
                            res_next.position = POS_W'(step_reg);
                        end
                    end
                    MODE_LIST:
                    begin
                        if ((step_reg >= tgt_reg) && (step_reg <= lastp_reg))
                        begin
                            res_v_next        = 1'b1;
                            res_next          = ign_res;
                            res_next.status   = STAT_DONE;
                            res_next.key      = OUT_KEY_W'(cell_key[0]);
                            res_next.position = POS_W'(step_reg);
                            res_next.last     = (step_reg == lastp_reg);
                        end
                    end
                    default:
                    begin
                        res_v_next = 1'b0;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            cur_reg   <= '0;
            step_reg  <= '0;
            mode_reg  <= MODE_GOTO;
            found_reg <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            step_reg  <= step_next;
            mode_reg  <= mode_next;
            found_reg <= found_next;
            res_v_reg <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seek_reg  <= seek_next;
        tgt_reg   <= tgt_next;
        lastp_reg <= lastp_next;
        res_reg   <= res_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            en_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CAPACITY: cap_reg <= CAP_W'(cfg_data);
                CFG_ENABLE:   en_reg  <= cfg_data[0];
                default:      en_reg  <= en_reg;
            endcase
        end
    end

    assign cfg_ready       = 1'b1;
    assign busy            = (state_reg == ST_SCAN);
    assign result_valid    = res_v_reg;
    assign status          = res_reg.status;
    assign result_key      = res_reg.key;
    assign result_position = res_reg.position;
    assign back_count      = res_reg.back;
    assign forward_count   = res_reg.fwd;
    assign current_present = res_reg.present;
    assign evicted         = res_reg.evicted;
    assign changed         = res_reg.changed;
    assign last            = res_reg.last;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (CW'(cur_reg) < cnt_reg))
        else $error("cursor beyond last entry");

    a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (cur_reg == '0))
        else $error("cursor set on empty list");

    a_add_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_ADD)) |=> result_valid)
        else $error("add request gave no result");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && scan_end) |=> (state_reg == ST_IDLE))
        else $error("ring scan did not finish after one turn");

endmodule

// ===== src/bhlc_cell.sv =====
// ----------------------------------------------------------------------------
// History list cell
// Holds one key of the list. Takes a new key when its own index is written,
// otherwise takes its right neighbor's key when the chain shifts.
// ----------------------------------------------------------------------------
module bhlc_cell #(
    parameter int KEY_WIDTH = bhlc_pkg::KEY_WIDTH_DEF,
    parameter int IW        = 6,
    parameter int INDEX     = 0
) (
    input  logic                 clk,
    input  logic                 shift,
    input  logic [KEY_WIDTH-1:0] next_key,
    input  logic                 wr_en,
    input  logic [IW-1:0]        wr_idx,
    input  logic [KEY_WIDTH-1:0] wr_key,
    output logic [KEY_WIDTH-1:0] key
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;

    always_comb
    begin
        key_next = key_reg;
        if (wr_en && (wr_idx == IW'(INDEX)))
        begin
            key_next = wr_key;
        end
        else if (shift)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule
